// ===== src/serial_time_command_parser_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the serial time command parser
// Short forms for clocked, reset-gated property checks.
// ----------------------------------------------------------------------------
`ifndef SERIAL_TIME_COMMAND_PARSER_CORE_ASSERT_SVH
`define SERIAL_TIME_COMMAND_PARSER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STCP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("parser check failed");

// The consequent must hold in the cycle after the antecedent.
`define STCP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("parser check failed");

`endif

// ===== src/stcp_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial time command parser package
// Shared constants, codes and small helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package stcp_pkg;

  // Line capacity, terminator excluded: the character that would fill it drops the line.
  localparam int LINE_CAPACITY = 96;
  localparam int LINE_CNT_W    = $clog2(LINE_CAPACITY);

  localparam logic [15:0] GAP_RESET  = 16'd300;
  localparam logic [15:0] TICKS_MAX  = 16'hFFFF;
  localparam logic [11:0] NUMBER_MAX = 12'd255;
  localparam logic [7:0]  HOUR_LIMIT = 8'd24;
  localparam logic [7:0]  MIN_LIMIT  = 8'd60;
  localparam logic [2:0]  TIME_LEN   = 3'd5;
  localparam logic [2:0]  PING_LEN   = 3'd4;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_P     = 8'h50;

  typedef enum logic [1:0] {
    CMD_BYTE     = 2'd0,
    CMD_TICK     = 2'd1,
    CMD_LINK_ERR = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REPLY_TIME_OK = 2'd0,
    REPLY_PONG    = 2'd1,
    REPLY_ERR     = 2'd2
  } reply_t;

  typedef enum logic [3:0] {
    PH_START      = 4'd0,
    PH_TIME_PFX   = 4'd1,
    PH_PING_PFX   = 4'd2,
    PH_PING_DONE  = 4'd3,
    PH_HOUR_FIRST = 4'd4,
    PH_HOUR       = 4'd5,
    PH_MIN_FIRST  = 4'd6,
    PH_MIN        = 4'd7,
    PH_SEC_FIRST  = 4'd8,
    PH_SEC        = 4'd9,
    PH_TRAIL      = 4'd10,
    PH_ERR        = 4'd11
  } phase_t;

  // Characters of "TIME," by position.
  function automatic logic [7:0] time_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h54;
      3'd1:    c = 8'h49;
      3'd2:    c = 8'h4D;
      3'd3:    c = 8'h45;
      3'd4:    c = 8'h2C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Characters of "PING" by position.
  function automatic logic [7:0] ping_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h50;
      3'd1:    c = 8'h49;
      3'd2:    c = 8'h4E;
      3'd3:    c = 8'h47;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  endfunction

endpackage

`default_nettype wire

// ===== src/stcp_cmd_if.sv =====
// ----------------------------------------------------------------------------
// Command channel
// Carries received bytes, millisecond ticks and link-error events.
// ----------------------------------------------------------------------------
`default_nettype none

interface stcp_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== src/stcp_reply_if.sv =====
// ----------------------------------------------------------------------------
// Reply channel
// Carries one reply per completed non-empty line.
// ----------------------------------------------------------------------------
`default_nettype none

interface stcp_reply_if;
  logic       valid;
  logic       ready;
  logic [1:0] reply;
  logic [4:0] hour;
  logic [5:0] minute;
  logic [5:0] second;

  modport source (output valid, output reply, output hour, output minute,
                  output second, input ready);
  modport sink   (input valid, input reply, input hour, input minute,
                  input second, output ready);
endinterface

`default_nettype wire

// ===== src/serial_time_command_parser_core.sv =====
// ----------------------------------------------------------------------------
// Serial time command parser core
// Parses "TIME,h,m,s" and "PING" lines from a byte stream and replies.
//
//   Channel   Direction  Contents
//   --------  ---------  ----------------------------------------------
//   request   in         command (byte, tick, link error), data_byte
//   response  out        reply (TIME_OK, PONG, ERR), hour, minute, second
//   cfg       in         gap_limit_ms write (cfg_we, cfg_wdata)
//
// Every item is handled in the cycle it is accepted: the line state registers
// update at that edge and any reply lands in the output register, so one
// item per cycle is sustained. The output register is the only stall point;
// a new item is taken whenever the register is empty or being drained this
// cycle. Reset (synchronous, rst high) empties the line, clears the idle
// counter and loads the gap limit with 300 ticks.
// ----------------------------------------------------------------------------
`default_nettype none

`include "serial_time_command_parser_core_assert.svh"

module serial_time_command_parser_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  stcp_cmd_if.sink         request,
  stcp_reply_if.source     response
);

  localparam int CW = stcp_pkg::LINE_CNT_W;
  localparam logic [CW-1:0] LAST_COUNT = CW'(stcp_pkg::LINE_CAPACITY - 1);

  // Line and timing state.
  logic [15:0]         gap_limit;
  logic [15:0]         idle_ticks, idle_ticks_next;
  logic [CW-1:0]       line_count, line_count_next;
  stcp_pkg::phase_t    phase, phase_next;
  logic [2:0]          prefix_pos, prefix_pos_next;
  logic [7:0]          digit_value, digit_value_next;
  logic [7:0]          saved_hour, saved_hour_next;
  logic [7:0]          saved_minute, saved_minute_next;
  logic                content_ended, content_ended_next;

  // Output register.
  logic                out_valid, out_valid_next;
  stcp_pkg::reply_t    out_reply, res_reply;
  logic [4:0]          out_hour, res_hour;
  logic [5:0]          out_minute, res_minute;
  logic [5:0]          out_second, res_second;
  logic                res_valid;

  logic                accept;
  logic [7:0]          b;
  logic [11:0]         digit_sum;
  logic [15:0]         ticks_inc;

  assign request.ready = !out_valid || response.ready;
  assign accept        = request.valid && request.ready;
  assign b             = request.data_byte;

  // Decimal accumulate: value * 10 + new digit, wide enough to see overflow.
  assign digit_sum = {1'b0, digit_value, 3'b000} + {3'b000, digit_value, 1'b0}
                   + {8'h00, b[3:0]};
  assign ticks_inc = (idle_ticks == stcp_pkg::TICKS_MAX) ? idle_ticks
                                                         : idle_ticks + 16'd1;

  always_comb begin
    idle_ticks_next    = idle_ticks;
    line_count_next    = line_count;
    phase_next         = phase;
    prefix_pos_next    = prefix_pos;
    digit_value_next   = digit_value;
    saved_hour_next    = saved_hour;
    saved_minute_next  = saved_minute;
    content_ended_next = content_ended;
    res_valid          = 1'b0;
    res_reply          = stcp_pkg::REPLY_ERR;
    res_hour           = '0;
    res_minute         = '0;
    res_second         = '0;

    if (accept) begin
      case (stcp_pkg::cmd_t'(request.command))
        stcp_pkg::CMD_TICK: begin
          idle_ticks_next = ticks_inc;
          if ((line_count != '0) && (ticks_inc > gap_limit)) begin
            line_count_next    = '0;
            phase_next         = stcp_pkg::PH_START;
            prefix_pos_next    = '0;
            digit_value_next   = '0;
            saved_hour_next    = '0;
            saved_minute_next  = '0;
            content_ended_next = 1'b0;
          end
        end
        stcp_pkg::CMD_LINK_ERR: begin
          line_count_next    = '0;
          phase_next         = stcp_pkg::PH_START;
          prefix_pos_next    = '0;
          digit_value_next   = '0;
          saved_hour_next    = '0;
          saved_minute_next  = '0;
          content_ended_next = 1'b0;
        end
        stcp_pkg::CMD_BYTE: begin
          idle_ticks_next = '0;
          if ((b == stcp_pkg::CHAR_LF) || (b == stcp_pkg::CHAR_CR)) begin
            // Line end: reply only if the line held something.
            if (line_count != '0) begin
              res_valid = 1'b1;
              if (phase == stcp_pkg::PH_PING_DONE) begin
                res_reply = stcp_pkg::REPLY_PONG;
              end else if (((phase == stcp_pkg::PH_SEC) ||
                             (phase == stcp_pkg::PH_TRAIL)) &&
                           (saved_hour < stcp_pkg::HOUR_LIMIT) &&
                           (saved_minute < stcp_pkg::MIN_LIMIT) &&
                           (digit_value < stcp_pkg::MIN_LIMIT)) begin
                res_reply  = stcp_pkg::REPLY_TIME_OK;
                res_hour   = saved_hour[4:0];
                res_minute = saved_minute[5:0];
                res_second = digit_value[5:0];
              end
            end
            line_count_next    = '0;
            phase_next         = stcp_pkg::PH_START;
            prefix_pos_next    = '0;
            digit_value_next   = '0;
            saved_hour_next    = '0;
            saved_minute_next  = '0;
            content_ended_next = 1'b0;
          end else if (line_count < LAST_COUNT) begin
            line_count_next = line_count + CW'(1);
            if (!content_ended) begin
              if (b == stcp_pkg::CHAR_NUL) begin
                // A zero byte ends the parsed content for the rest of the line.
                content_ended_next = 1'b1;
              end else begin
                case (phase)
                  stcp_pkg::PH_START: begin
                    prefix_pos_next = 3'd1;
                    if (b == stcp_pkg::CHAR_T) begin
                      phase_next = stcp_pkg::PH_TIME_PFX;
                    end else if (b == stcp_pkg::CHAR_P) begin
                      phase_next = stcp_pkg::PH_PING_PFX;
                    end else begin
                      prefix_pos_next = prefix_pos;
                      phase_next      = stcp_pkg::PH_ERR;
                    end
                  end
                  stcp_pkg::PH_TIME_PFX: begin
                    if ((prefix_pos < stcp_pkg::TIME_LEN) &&
                        (b == stcp_pkg::time_char(prefix_pos))) begin
                      prefix_pos_next = prefix_pos + 3'd1;
                      if (prefix_pos + 3'd1 == stcp_pkg::TIME_LEN) begin
                        phase_next = stcp_pkg::PH_HOUR_FIRST;
                      end
                    end else begin
                      phase_next = stcp_pkg::PH_ERR;
                    end
                  end
                  stcp_pkg::PH_PING_PFX: begin
                    if ((prefix_pos < stcp_pkg::PING_LEN) &&
                        (b == stcp_pkg::ping_char(prefix_pos))) begin
                      prefix_pos_next = prefix_pos + 3'd1;
                      if (prefix_pos + 3'd1 == stcp_pkg::PING_LEN) begin
                        phase_next = stcp_pkg::PH_PING_DONE;
                      end
                    end else begin
                      phase_next = stcp_pkg::PH_ERR;
                    end
                  end
                  stcp_pkg::PH_HOUR_FIRST, stcp_pkg::PH_MIN_FIRST,
                  stcp_pkg::PH_SEC_FIRST: begin
                    if (stcp_pkg::is_digit(b)) begin
                      digit_value_next = {4'h0, b[3:0]};
                      phase_next       = stcp_pkg::phase_t'(phase + 4'd1);
                    end else begin
                      phase_next = stcp_pkg::PH_ERR;
                    end
                  end
                  stcp_pkg::PH_HOUR, stcp_pkg::PH_MIN, stcp_pkg::PH_SEC: begin
                    if (stcp_pkg::is_digit(b)) begin
                      if (digit_sum > stcp_pkg::NUMBER_MAX) begin
                        phase_next = stcp_pkg::PH_ERR;
                      end else begin
                        digit_value_next = digit_sum[7:0];
                      end
                    end else if ((b == stcp_pkg::CHAR_COMMA) &&
                                 (phase != stcp_pkg::PH_SEC)) begin
                      if (phase == stcp_pkg::PH_HOUR) begin
                        saved_hour_next = digit_value;
                      end else begin
                        saved_minute_next = digit_value;
                      end
                      digit_value_next = '0;
                      phase_next       = stcp_pkg::phase_t'(phase + 4'd1);
                    end else if ((b == stcp_pkg::CHAR_SPACE) &&
                                 (phase == stcp_pkg::PH_SEC)) begin
                      phase_next = stcp_pkg::PH_TRAIL;
                    end else begin
                      phase_next = stcp_pkg::PH_ERR;
                    end
                  end
                  stcp_pkg::PH_TRAIL: begin
                    if (b != stcp_pkg::CHAR_SPACE) begin
                      phase_next = stcp_pkg::PH_ERR;
                    end
                  end
                  default: begin
                    phase_next = stcp_pkg::PH_ERR;
                  end
                endcase
              end
            end
          end else begin
            // Overlong line: drop it and start over empty.
            line_count_next    = '0;
            phase_next         = stcp_pkg::PH_START;
            prefix_pos_next    = '0;
            digit_value_next   = '0;
            saved_hour_next    = '0;
            saved_minute_next  = '0;
            content_ended_next = 1'b0;
          end
        end
        default: begin
          // The unused command code is taken and has no effect.
        end
      endcase
    end

    if (accept && res_valid) begin
      out_valid_next = 1'b1;
    end else if (response.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_limit     <= stcp_pkg::GAP_RESET;
      idle_ticks    <= '0;
      line_count    <= '0;
      phase         <= stcp_pkg::PH_START;
      prefix_pos    <= '0;
      digit_value   <= '0;
      saved_hour    <= '0;
      saved_minute  <= '0;
      content_ended <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        gap_limit <= cfg_wdata;
      end
      idle_ticks    <= idle_ticks_next;
      line_count    <= line_count_next;
      phase         <= phase_next;
      prefix_pos    <= prefix_pos_next;
      digit_value   <= digit_value_next;
      saved_hour    <= saved_hour_next;
      saved_minute  <= saved_minute_next;
      content_ended <= content_ended_next;
      out_valid     <= out_valid_next;
    end
  end

  // Payload register loads only when a new reply is produced.
  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_reply  <= res_reply;
      out_hour   <= res_hour;
      out_minute <= res_minute;
      out_second <= res_second;
    end
  end

  assign response.valid  = out_valid;
  assign response.reply  = out_reply;
  assign response.hour   = out_hour;
  assign response.minute = out_minute;
  assign response.second = out_second;

  // A time reply always carries in-range fields; other replies carry zeros.
  `STCP_ASSERT_NOW(a_time_in_range,
    out_valid && (out_reply == stcp_pkg::REPLY_TIME_OK),
    (out_hour < 5'd24) && (out_minute < 6'd60) && (out_second < 6'd60))
  `STCP_ASSERT_NOW(a_other_zero,
    out_valid && (out_reply != stcp_pkg::REPLY_TIME_OK),
    (out_hour == '0) && (out_minute == '0) && (out_second == '0))
  // The line count never reaches the capacity.
  `STCP_ASSERT_NOW(a_count_bound, 1'b1, line_count <= LAST_COUNT)
  // A zero byte can only have been counted into a non-empty line.
  `STCP_ASSERT_NOW(a_ended_nonempty, content_ended, line_count != '0)
  // Any line end leaves an empty line behind.
  `STCP_ASSERT_NEXT(a_end_clears,
    accept && (request.command == stcp_pkg::CMD_BYTE) &&
      ((b == stcp_pkg::CHAR_LF) || (b == stcp_pkg::CHAR_CR)),
    (line_count == '0) && (phase == stcp_pkg::PH_START))

endmodule

`default_nettype wire
